// ===== design/lcdw_pkg.sv =====
package lcdw_pkg;

  typedef enum logic [1:0] {
    KIND_CORNERS = 2'd0,
    KIND_SIZE    = 2'd1,
    KIND_PIXEL   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ORIENT = 2'd0,
    CFG_SHORT  = 2'd1,
    CFG_LONG   = 2'd2,
    CFG_NARROW = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ORIENT_PORTRAIT      = 2'd0,
    ORIENT_LANDSCAPE     = 2'd1,
    ORIENT_PORTRAIT_REV  = 2'd2,
    ORIENT_LANDSCAPE_REV = 2'd3
  } orient_e;

  // panel controller register indexes
  localparam logic [15:0] REG_H_WIN_END   = 16'h0036;
  localparam logic [15:0] REG_H_WIN_START = 16'h0037;
  localparam logic [15:0] REG_V_WIN_END   = 16'h0038;
  localparam logic [15:0] REG_V_WIN_START = 16'h0039;
  localparam logic [15:0] REG_RAM_ADDR_H  = 16'h0020;
  localparam logic [15:0] REG_RAM_ADDR_V  = 16'h0021;
  localparam logic [15:0] REG_GRAM_DATA   = 16'h0022;

  localparam logic [15:0] HI_MASK = 16'hFF00;
  localparam logic [15:0] LO_MASK = 16'h00FF;

  localparam logic [9:0] SHORT_RST = 10'd176;
  localparam logic [9:0] LONG_RST  = 10'd220;

  localparam int unsigned IDX_W = 5;
  localparam logic [3:0] GRAM_WORD_IDX = 4'd12;
  // index of the final bus word per request type and bus mode
  localparam logic [IDX_W-1:0] LAST_PIX_WIDE   = 5'd0;
  localparam logic [IDX_W-1:0] LAST_PIX_NARROW = 5'd1;
  localparam logic [IDX_W-1:0] LAST_WIN_WIDE   = 5'd12;
  localparam logic [IDX_W-1:0] LAST_WIN_NARROW = 5'd25;

  typedef struct packed {
    logic [15:0] h_start;
    logic [15:0] h_end;
    logic [15:0] v_start;
    logic [15:0] v_end;
    logic [15:0] ram_h;
    logic [15:0] ram_v;
  } win_t;

  typedef struct packed {
    orient_e    orient;
    logic [9:0] short_side;
    logic [9:0] long_side;
  } panel_t;

endpackage

// ===== design/lcdw_map.sv =====
module lcdw_map
  import lcdw_pkg::*;
(
  input  panel_t     panel_i,
  input  logic       by_size_i,
  input  logic [9:0] start_col_i,
  input  logic [9:0] start_row_i,
  input  logic [9:0] extent_col_i,
  input  logic [9:0] extent_row_i,
  output win_t       win_o
);

  logic [15:0] sx, sy, ex, ey, sh, lg;
  logic [15:0] sh_ex, sh_sx, sh_ey, sh_sy, lg_ex, lg_sx, lg_ey, lg_sy;

  always_comb begin
    sx = {6'd0, start_col_i};
    sy = {6'd0, start_row_i};
    sh = {6'd0, panel_i.short_side};
    lg = {6'd0, panel_i.long_side};
    // size form: end = start + size - 1, wrapping at 16 bits
    if (by_size_i) begin
      ex = sx + {6'd0, extent_col_i} - 16'd1;
      ey = sy + {6'd0, extent_row_i} - 16'd1;
    end else begin
      ex = {6'd0, extent_col_i};
      ey = {6'd0, extent_row_i};
    end
    // mirrored coordinates: side - c - 1
    sh_ex = sh - ex - 16'd1;
    sh_sx = sh - sx - 16'd1;
    sh_ey = sh - ey - 16'd1;
    sh_sy = sh - sy - 16'd1;
    lg_ex = lg - ex - 16'd1;
    lg_sx = lg - sx - 16'd1;
    lg_ey = lg - ey - 16'd1;
    lg_sy = lg - sy - 16'd1;

    case (panel_i.orient)
      ORIENT_PORTRAIT:      win_o = '{sx, ex, sy, ey, sx, sy};
      ORIENT_LANDSCAPE:     win_o = '{sy, ey, lg_ex, lg_sx, sy, lg_ex};
      ORIENT_PORTRAIT_REV:  win_o = '{sh_ex, sh_sx, lg_ey, lg_sy, sh_sx, lg_sy};
      ORIENT_LANDSCAPE_REV: win_o = '{sh_ey, sh_sy, sx, ex, sh_sy, sx};
      default:              win_o = '{sx, ex, sy, ey, sx, sy};
    endcase
  end

endmodule

// ===== design/lcd_window_command_sequencer_top.sv =====
// Start: a request accepted at a clock edge loads act_q and idx_q; its first bus word is then
// registered into word_q and strobe_q, from which the receiver takes it.
// Throughput: a pixel request is one bus word (two in byte mode); a window request is
// 13 words (26 in byte mode), one bus word per cycle set by the word counter.
// busy_o holds off start_i until the current request is on its final word.
// The receiver cannot stall: every strobe_o cycle carries one word.
// Reset (asynchronous, active low) drops any request in flight and restores config defaults.
module lcd_window_command_sequencer_top
  import lcdw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  start_col_i,
  input  logic [9:0]  start_row_i,
  input  logic [9:0]  extent_col_i,
  input  logic [9:0]  extent_row_i,
  input  logic [15:0] pixel_value_i,
  output logic        strobe_o,
  output logic        is_data_o,
  output logic [15:0] bus_word_o,
  output logic        last_o
);

  panel_t panel_q;
  logic   narrow_q;

  logic             act_q;
  logic [IDX_W-1:0] idx_q;
  logic             is_pix_q;
  logic [15:0]      pix_q;
  win_t             win_q;
  win_t             win_d;

  logic        strobe_q, is_data_q, last_q;
  logic [15:0] word_q;

  logic             accept, load, cur_last;
  logic [IDX_W-1:0] last_idx;
  logic [3:0]       w_idx;
  logic             w_is_data, b_is_data;
  logic [15:0]      w_word, b_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_q <= '{ORIENT_PORTRAIT, SHORT_RST, LONG_RST};
      narrow_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIENT: panel_q.orient <= orient_e'(cfg_data_i[1:0]);
        CFG_SHORT:  panel_q.short_side <= cfg_data_i;
        CFG_LONG:   panel_q.long_side <= cfg_data_i;
        CFG_NARROW: narrow_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lcdw_map u_map (
    .panel_i      (panel_q),
    .by_size_i    (kind_i == KIND_SIZE),
    .start_col_i  (start_col_i),
    .start_row_i  (start_row_i),
    .extent_col_i (extent_col_i),
    .extent_row_i (extent_row_i),
    .win_o        (win_d)
  );

  always_comb begin
    if (is_pix_q) begin
      last_idx = narrow_q ? LAST_PIX_NARROW : LAST_PIX_WIDE;
    end else begin
      last_idx = narrow_q ? LAST_WIN_NARROW : LAST_WIN_WIDE;
    end
    cur_last = act_q && (idx_q == last_idx);
    busy_o   = act_q && !cur_last;
    accept   = start_i && !busy_o;
    // the unused kind code gives no words
    load     = accept && (kind_i == KIND_CORNERS || kind_i == KIND_SIZE ||
                          kind_i == KIND_PIXEL);
  end

  // select the word, then the byte in narrow mode
  always_comb begin
    w_idx = narrow_q ? idx_q[4:1] : idx_q[3:0];
    if (is_pix_q) begin
      w_is_data = 1'b1;
      w_word    = pix_q;
    end else if (w_idx == GRAM_WORD_IDX) begin
      w_is_data = 1'b0;
      w_word    = REG_GRAM_DATA;
    end else begin
      w_is_data = w_idx[0];
      case (w_idx[3:1])
        3'd0:    w_word = w_idx[0] ? win_q.h_start : REG_H_WIN_START;
        3'd1:    w_word = w_idx[0] ? win_q.h_end   : REG_H_WIN_END;
        3'd2:    w_word = w_idx[0] ? win_q.v_start : REG_V_WIN_START;
        3'd3:    w_word = w_idx[0] ? win_q.v_end   : REG_V_WIN_END;
        3'd4:    w_word = w_idx[0] ? win_q.ram_h   : REG_RAM_ADDR_H;
        3'd5:    w_word = w_idx[0] ? win_q.ram_v   : REG_RAM_ADDR_V;
        default: w_word = REG_GRAM_DATA;
      endcase
    end
    b_is_data = w_is_data;
    if (!narrow_q) begin
      b_word = w_word;
    end else if (!idx_q[0]) begin
      b_word = (w_word & HI_MASK) >> 8;
    end else begin
      b_word = w_word & LO_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= act_q;
      if (load) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (cur_last) begin
        act_q <= 1'b0;
      end else if (act_q) begin
        idx_q <= idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_pix_q <= (kind_i == KIND_PIXEL);
      pix_q    <= pixel_value_i;
      win_q    <= win_d;
    end
    is_data_q <= b_is_data;
    word_q    <= b_word;
    last_q    <= cur_last;
  end

  assign strobe_o   = strobe_q;
  assign is_data_o  = is_data_q;
  assign bus_word_o = word_q;
  assign last_o     = last_q;

`ifndef SYNTHESIS
  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> act_q)
    else $error("busy without an active request");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (act_q && idx_q == '0))
    else $error("accepted request did not start at word zero");

  a_word_each_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |=> strobe_o)
    else $error("active cycle produced no bus word");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> act_q)
    else $error("request ended before its final word");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q |=> !strobe_o)
    else $error("bus word while idle");
`endif

endmodule
